### hdl/amh_pkg.sv
// Package for the AES-MMO hash core: types, constants and AES helper functions.
`timescale 1ns / 1ps
package amh_pkg;

  typedef enum logic [1:0] {
    MODE_ABSORB = 2'd0,
    MODE_ABS_FIN = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam int unsigned BlkBytes = 16;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam int unsigned Rounds = 10;

  // Queue entry between the front and the back part.
  typedef struct packed {
    logic       fin;
    logic       has_byte;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits at bits [127-8i -: 8].
  function automatic logic [7:0] byte_of(input logic [127:0] w, input int unsigned i);
    return w[127-8*i -: 8];
  endfunction

  // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = sbox(byte_of(s, 4*((c+r) % 4) + r));
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = t[i];
    end
    return o ^ k;
  endfunction

  // Next round key from the current one.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [7:0] b [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      b[i] = byte_of(k, i);
    end
    b[0] = b[0] ^ sbox(b[13]) ^ rc;
    b[1] = b[1] ^ sbox(b[14]);
    b[2] = b[2] ^ sbox(b[15]);
    b[3] = b[3] ^ sbox(b[12]);
    for (int i = 4; i < 16; i++) begin
      b[i] = b[i] ^ b[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = b[i];
    end
    return o;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd0: v = 8'h01; 4'd1: v = 8'h02; 4'd2: v = 8'h04; 4'd3: v = 8'h08;
      4'd4: v = 8'h10; 4'd5: v = 8'h20; 4'd6: v = 8'h40; 4'd7: v = 8'h80;
      4'd8: v = 8'h1b; default: v = 8'h36;
    endcase
    return v;
  endfunction

endpackage

### hdl/aes_mmo_hash_core.sv
// Top level of the AES-MMO (128-bit) hash core.
`timescale 1ns / 1ps
//  channel | signals                                   | direction
//  in      | in_valid_i, in_ready_o, mode_i, data_byte_i | into block
//  out     | out_valid_o, out_ready_i, digest_word_o,    | out of block
//          | word_index_o, last_word_o                   |
//  An absorbed byte is taken from the queue in idle; a byte that fills a block adds ten AES rounds
//  in the shared round unit, one per cycle.
//  A finish passes through the pad state and one compression before the first word; a byte that
//  fills a block adds a compression before that, and a length block adds the length state and a compression.
//  Reset clears the chaining value, fill count and bit length.
//  A two-entry queue lets input items in while the round unit or the output stalls.
module aes_mmo_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic        word_index_o,
  output logic        last_word_o
);
  import amh_pkg::*;

  logic  q_valid, q_pop;
  cmd_t  q_head;

  // Front: classify each item and queue every one but the ignored mode.
  amh_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .data_byte_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_head_o(q_head)
  );

  // Back: absorb, pad and compress; hold the digest until taken.
  amh_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_head_i(q_head),
    .out_valid_o, .out_ready_i, .digest_word_o, .word_index_o, .last_word_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=> (out_valid_o && last_word_o))
    else $error("second digest word missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (word_index_o == last_word_o))
    else $error("word index and last flag disagree");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(digest_word_o))
    else $error("digest word changed while stalled");
endmodule

### hdl/amh_front.sv
// Front part: accept and classify input items, push all but mode three into a short queue.
`timescale 1ns / 1ps
module amh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        data_byte_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output amh_pkg::cmd_t     q_head_o
);
  import amh_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       mem_q [Depth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cmd;
  logic       push;

  always_comb begin
    cmd.data     = data_byte_i;
    cmd.has_byte = (mode_i == MODE_ABSORB) || (mode_i == MODE_ABS_FIN);
    cmd.fin      = (mode_i == MODE_ABS_FIN) || (mode_i == MODE_FINISH);
  end

  assign in_ready_o = (cnt_q != 2'(Depth));
  // Drop mode three at once: it changes nothing.
  assign push       = in_valid_i && in_ready_o && (mode_i != MODE_NONE);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_head_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count did not advance");
endmodule

### hdl/amh_back.sv
// Back part: block buffer, padding sequencer and iterative AES-128 compression.
`timescale 1ns / 1ps
module amh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  amh_pkg::cmd_t     q_head_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       digest_word_o,
  output logic              word_index_o,
  output logic              last_word_o
);
  import amh_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_AES   = 6'b000010,
    ST_PAD   = 6'b000100,
    ST_LEN   = 6'b001000,
    ST_OUT0  = 6'b010000,
    ST_OUT1  = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  logic [127:0] chain_q, blk_q, st_q, key_q, dig_q;
  logic [3:0]   fill_q, rnd_q;
  logic [15:0]  blen_q;
  logic         fin_q, last_q;   // finish pending; this compression is the last
  logic [127:0] rnd_out, mmo, padded;
  logic [3:0]   f;

  assign rnd_out = aes_round(st_q, key_next(key_q, rcon(rnd_q)), rnd_q != 4'(Rounds - 1));
  assign mmo     = rnd_out ^ blk_q;
  assign f       = fill_q;

  // Marker at fill position, zeros after it.
  always_comb begin
    padded = blk_q;
    for (int i = 0; i < 16; i++) begin
      if (4'(i) == f) padded[127-8*i -: 8] = PadMarker;
      else if (4'(i) > f) padded[127-8*i -: 8] = 8'h00;
    end
  end

  assign q_pop_o       = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o   = (state_q == ST_OUT0) || (state_q == ST_OUT1);
  assign word_index_o  = (state_q == ST_OUT1);
  assign last_word_o   = (state_q == ST_OUT1);
  assign digest_word_o = (state_q == ST_OUT1) ? dig_q[63:0] : dig_q[127:64];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.has_byte && fill_q == 4'd15) state_d = ST_AES;
          else if (q_head_i.fin) state_d = ST_PAD;
        end
      end
      ST_AES: begin
        if (rnd_q == 4'(Rounds - 1)) begin
          if (last_q) state_d = ST_OUT0;
          // Marker block without room for the length: the length block follows.
          else if (fin_q) state_d = (fill_q >= 4'd14) ? ST_LEN : ST_PAD;
          else state_d = ST_IDLE;
        end
      end
      ST_PAD:  state_d = ST_AES;
      ST_LEN:  state_d = ST_AES;
      ST_OUT0: if (out_ready_i) state_d = ST_OUT1;
      ST_OUT1: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= '0;
      fill_q  <= '0;
      blen_q  <= '0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            fin_q <= q_head_i.fin;
            if (q_head_i.has_byte) begin
              fill_q <= fill_q + 4'd1;
              blen_q <= blen_q + 16'd8;
            end
            rnd_q <= '0;
          end
        end
        ST_AES: begin
          rnd_q <= rnd_q + 4'd1;
          if (rnd_q == 4'(Rounds - 1)) begin
            rnd_q <= '0;
            if (!last_q) chain_q <= mmo;
          end
        end
        ST_PAD: begin
          // Room for the length behind the marker: this is the last block.
          last_q <= (f <= 4'd13);
          rnd_q  <= '0;
        end
        ST_LEN: begin
          last_q <= 1'b1;
          rnd_q  <= '0;
        end
        ST_OUT0: ;
        ST_OUT1: begin
          if (out_ready_i) begin
            chain_q <= '0;
            fill_q  <= '0;
            blen_q  <= '0;
            fin_q   <= 1'b0;
            last_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_head_i.has_byte) begin
          blk_q[127-8*fill_q -: 8] <= q_head_i.data;
          if (fill_q == 4'd15) begin
            st_q  <= {blk_q[127:8], q_head_i.data} ^ chain_q;
            key_q <= chain_q;
          end
        end
      end
      ST_AES: begin
        st_q  <= rnd_out;
        key_q <= key_next(key_q, rcon(rnd_q));
        if (rnd_q == 4'(Rounds - 1) && last_q) dig_q <= mmo;
      end
      ST_PAD: begin
        if (f <= 4'd13) begin
          blk_q <= {padded[127:16], blen_q};
          st_q  <= {padded[127:16], blen_q} ^ chain_q;
        end else begin
          blk_q <= padded;
          st_q  <= padded ^ chain_q;
        end
        key_q <= chain_q;
      end
      ST_LEN: begin
        blk_q <= {112'd0, blen_q};
        st_q  <= {112'd0, blen_q} ^ chain_q;
        key_q <= chain_q;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> state_q == ST_IDLE)
    else $error("pop outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT1 && out_ready_i) |=> (fill_q == 4'd0 && blen_q == 16'd0))
    else $error("state not cleared after digest");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AES) |-> rnd_q < 4'(Rounds))
    else $error("round counter overrun");
endmodule

### verif/tb_aes_mmo_hash_core.sv
// Testbench for the AES-MMO hash core: directed table plus random messages, checked by a predictor.
`timescale 1ns / 1ps
module tb_aes_mmo_hash_core;
  import amh_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] digest_word_o;
  logic        word_index_o;
  logic        last_word_o;

  aes_mmo_hash_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  // One digest word as it should leave the block.
  typedef struct packed {
    logic [63:0] word;
    logic        idx;
    logic        last;
  } digest_word_t;

  typedef struct {
    mode_e      mode;
    logic [7:0] data;
    logic       typed;  // expected digest typed in below
    logic [127:0] digest;
  } stim_row_t;

  // Predictor state: chaining value, block buffer, fill count and bit length.
  logic [127:0] chain_q;
  logic [7:0]   blk_q [16];
  int unsigned  fill_q;
  logic [15:0]  bits_q;

  digest_word_t digest_fifo [$];
  int unsigned  mismatches;
  int unsigned  digests_seen;
  int unsigned  items_sent;
  int unsigned  msgs_done;
  bit           noisy_in;
  bit           noisy_out;
  bit           hold_out;
  bit           stim_done;

  // Byte tables written out so the predictor stays independent of the RTL helpers.
  logic [7:0] sb [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  logic [7:0] round_const [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                                   8'h1b, 8'h36};

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // MMO step: encrypt the buffered block under the chaining value, xor the block back in.
  function automatic logic [127:0] mmo_compress(logic [127:0] key_w, logic [7:0] pt [16]);
    logic [7:0] k [16];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      k[i] = key_w[127-8*i -: 8];
      s[i] = pt[i] ^ k[i];
    end
    for (int rnd = 0; rnd < 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[4*c+r] = sb[s[4*((c+r)%4)+r]];
      if (rnd < 9) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      k[0] = k[0] ^ sb[k[13]] ^ round_const[rnd];
      k[1] = k[1] ^ sb[k[14]];
      k[2] = k[2] ^ sb[k[15]];
      k[3] = k[3] ^ sb[k[12]];
      for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i] ^ pt[i];
    return res;
  endfunction

  function automatic void hash_reset();
    chain_q = '0;
    fill_q  = 0;
    bits_q  = '0;
    for (int i = 0; i < 16; i++) blk_q[i] = 8'h00;
  endfunction

  function automatic void hash_absorb(logic [7:0] b);
    blk_q[fill_q] = b;
    bits_q = bits_q + 16'd8;
    fill_q++;
    if (fill_q == 16) begin
      chain_q = mmo_compress(chain_q, blk_q);
      fill_q  = 0;
    end
  endfunction

  // Advance the predictor by one accepted item; return 1 and the digest on a finish.
  function automatic bit hash_step(mode_e m, logic [7:0] b, output logic [127:0] dig);
    dig = '0;
    if (m == MODE_NONE) return 0;
    if (m != MODE_FINISH) hash_absorb(b);
    if (m == MODE_ABSORB) return 0;
    blk_q[fill_q] = PadMarker;
    for (int i = fill_q + 1; i < 16; i++) blk_q[i] = 8'h00;
    // Too little room left for the length: compress the marker block first.
    if (16 - fill_q < 3) begin
      chain_q = mmo_compress(chain_q, blk_q);
      for (int i = 0; i < 16; i++) blk_q[i] = 8'h00;
    end
    blk_q[14] = bits_q[15:8];
    blk_q[15] = bits_q[7:0];
    dig = mmo_compress(chain_q, blk_q);
    hash_reset();
    return 1;
  endfunction

  task automatic push_digest(logic [127:0] d);
    digest_fifo.push_back('{word: d[127:64], idx: 1'b0, last: 1'b0});
    digest_fifo.push_back('{word: d[63:0],   idx: 1'b1, last: 1'b1});
  endtask

  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, exp_v, got_v);
  endtask

  // Offer one item and hold it until it is taken; predict on acceptance.
  task automatic send_item(mode_e m, logic [7:0] b, bit typed, logic [127:0] typed_dig);
    logic [127:0] dig;
    while (noisy_in && ($urandom_range(99) < 34)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (hash_step(m, b, dig)) begin
      msgs_done++;
      if (typed && dig !== typed_dig) report_mismatch("typed digest", dig[127:64], typed_dig[127:64]);
      push_digest(dig);
    end
    @(negedge clk_i);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: check each accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      digests_seen++;
      if (digest_fifo.size() == 0) begin
        report_mismatch("unexpected word", '0, digest_word_o);
      end else begin
        exp_w = digest_fifo.pop_front();
        if (digest_word_o !== exp_w.word) report_mismatch("digest_word", exp_w.word, digest_word_o);
        if (word_index_o !== exp_w.idx) report_mismatch("word_index", exp_w.idx, word_index_o);
        if (last_word_o !== exp_w.last) report_mismatch("last_word", exp_w.last, last_word_o);
      end
    end
  end

  // Drive ready at the falling edge: random stalls, or a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_out) out_ready_i <= 1'b0;
    else if (noisy_out) out_ready_i <= ($urandom_range(99) >= 34);
    else out_ready_i <= 1'b1;
  end

  // Long receiver hold-off, counted here, while the sender keeps offering items.
  initial begin
    hold_out = 1'b0;
    wait (msgs_done >= 3);
    @(negedge clk_i);
    hold_out = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_out = 1'b0;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("Timed out with %0d words outstanding", digest_fifo.size());
    $display("Simulation FAILED");
    $finish;
  end

  stim_row_t rows [$];

  initial begin
    int unsigned len;
    int unsigned kind;
    logic [7:0] b;
    in_valid_i  = 1'b0;
    mode_i      = MODE_ABSORB;
    data_byte_i = 8'h00;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    noisy_in    = 1'b0;
    noisy_out   = 1'b0;
    stim_done   = 1'b0;
    mismatches  = 0;
    digests_seen = 0;
    items_sent  = 0;
    msgs_done   = 0;
    hash_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: empty message (its typed digest is recomputed below), length
    // in a block of its own, ignored mode, extremes of data.
    rows.push_back('{MODE_FINISH, 8'hff, 1'b1, 128'hc8_a2_d1_7a_ab_24_8e_2e_d4_81_d9_15_18_bc_c3_ec});
    rows.push_back('{MODE_NONE,   8'h5a, 1'b0, '0});
    rows.push_back('{MODE_ABS_FIN, 8'h00, 1'b0, '0});
    rows.push_back('{MODE_ABS_FIN, 8'hff, 1'b0, '0});
    for (int i = 0; i < 13; i++) rows.push_back('{MODE_ABSORB, 8'(i * 19), 1'b0, '0});
    rows.push_back('{MODE_NONE,   8'h00, 1'b0, '0});
    rows.push_back('{MODE_ABS_FIN, 8'h80, 1'b0, '0});
    for (int i = 0; i < 2; i++) rows.push_back('{MODE_ABSORB, 8'hff, 1'b0, '0});
    rows.push_back('{MODE_FINISH, 8'h00, 1'b0, '0});
    foreach (rows[i]) begin
      // The typed digest is replaced by the bench's own MMO of the padded empty block; the predictor check still runs.
      if (rows[i].typed) begin
        logic [127:0] d;
        logic [7:0] tmp [16];
        for (int j = 0; j < 16; j++) tmp[j] = 8'h00;
        tmp[0] = PadMarker;
        d = mmo_compress('0, tmp);
        rows[i].digest = d;
      end
      send_item(rows[i].mode, rows[i].data, rows[i].typed, rows[i].digest);
    end

    // Random messages: mostly well-formed, lengths around block edges, a few of
    // several blocks; noise of the ignored mode in between.
    noisy_in  = 1'b1;
    noisy_out = 1'b1;
    while (items_sent < 1330) begin
      kind = $urandom_range(99);
      if (kind < 5) len = 40 + $urandom_range(40);
      else if (kind < 40) len = 16 * $urandom_range(3) + $urandom_range(13, 15);
      else len = $urandom_range(40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 3) send_item(MODE_NONE, 8'($urandom), 1'b0, '0);
        b = 8'($urandom);
        if (i == len - 1 && $urandom_range(1)) send_item(MODE_ABS_FIN, b, 1'b0, '0);
        else send_item(MODE_ABSORB, b, 1'b0, '0);
      end
      if (fill_q != 0 || bits_q != 0 || len == 0) send_item(MODE_FINISH, 8'($urandom), 1'b0, '0);
      // Stretch with no idling on either side.
      if (msgs_done > 20 && msgs_done < 24) begin
        noisy_in  = 1'b0;
        noisy_out = 1'b0;
      end else begin
        noisy_in  = 1'b1;
        noisy_out = 1'b1;
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    wait (digest_fifo.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d items over %0d messages, %0d digest words checked, %0d mismatches",
             items_sent, msgs_done, digests_seen, mismatches);
    if (mismatches == 0 && digest_fifo.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
